@@ sv/ipv4_dotted_quad_checker_top_macros.svh @@
// Assertion helpers shared by the checker RTL.
`ifndef IPV4_DOTTED_QUAD_CHECKER_TOP_MACROS_SVH
`define IPV4_DOTTED_QUAD_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPV4DQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPV4DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ipv4dq_pkg.sv @@
package ipv4dq_pkg;

   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned VALUE_W = 8;
   localparam int unsigned CHARS_W = 3;
   localparam int unsigned INDEX_W = 2;
   localparam int unsigned RSP_W   = 8;

   localparam logic [COUNT_W-1:0] LEN_MIN         = COUNT_W'(7);
   localparam logic [COUNT_W-1:0] LEN_MAX         = COUNT_W'(15);
   localparam logic [COUNT_W-1:0] COUNT_SAT       = COUNT_W'(16);
   localparam logic [CHARS_W-1:0] FIELD_UNITS_MAX = CHARS_W'(4);
   localparam logic [INDEX_W-1:0] LAST_FIELD      = INDEX_W'(3);
   localparam logic [11:0]        OCTET_MAX       = 12'd255;
   localparam logic [UNIT_W-1:0]  DOT_UNIT        = 16'h002E;
   localparam logic [UNIT_W-1:0]  DIGIT_0         = 16'h0030;
   localparam logic [UNIT_W-1:0]  DIGIT_9         = 16'h0039;

   typedef struct packed {
      logic [COUNT_W-1:0] char_count;
      logic [INDEX_W-1:0] field_index;
      logic [VALUE_W-1:0] field_value;
      logic [CHARS_W-1:0] field_chars;
      logic               field_has_digit;
      logic               failed;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '0;

endpackage

@@ sv/ipv4dq_unit_step.sv @@
module ipv4dq_unit_step (
   input  ipv4dq_pkg::scan_state_type      cur_state,
   input  logic [ipv4dq_pkg::UNIT_W-1:0]   code_unit,
   output ipv4dq_pkg::scan_state_type      next_state,
   output logic                            string_ok
);
   import ipv4dq_pkg::*;

   logic        is_digit;
   logic        is_dot;
   logic [3:0]  digit;
   logic [11:0] scaled;
   logic [11:0] wide_value;

   assign is_digit   = (code_unit >= DIGIT_0) && (code_unit <= DIGIT_9);
   assign is_dot     = (code_unit == DOT_UNIT);
   assign digit      = code_unit[3:0];
   // times ten as 8x + 2x
   assign scaled     = {1'b0, cur_state.field_value, 3'b000}
                     + {3'b000, cur_state.field_value, 1'b0};
   assign wide_value = scaled + {8'h00, digit};

   always_comb begin
      next_state = cur_state;
      if (cur_state.char_count < COUNT_SAT) begin
         next_state.char_count = cur_state.char_count + COUNT_W'(1);
      end
      if (!cur_state.failed) begin
         if (cur_state.field_chars >= FIELD_UNITS_MAX) begin
            next_state.failed = 1'b1;
         end else if (is_digit) begin
            if (wide_value > OCTET_MAX) begin
               next_state.failed = 1'b1;
            end else begin
               next_state.field_value     = wide_value[VALUE_W-1:0];
               next_state.field_has_digit = 1'b1;
               next_state.field_chars     = cur_state.field_chars + CHARS_W'(1);
            end
         end else if (is_dot) begin
            if (!cur_state.field_has_digit || (cur_state.field_index >= LAST_FIELD)) begin
               next_state.failed = 1'b1;
            end else begin
               next_state.field_index     = cur_state.field_index + INDEX_W'(1);
               next_state.field_value     = '0;
               next_state.field_chars     = '0;
               next_state.field_has_digit = 1'b0;
            end
         end else begin
            next_state.failed = 1'b1;
         end
      end
   end

   assign string_ok = !next_state.failed
                    && (next_state.char_count >= LEN_MIN)
                    && (next_state.char_count <= LEN_MAX)
                    && (next_state.field_index == LAST_FIELD)
                    && next_state.field_has_digit;

endmodule

@@ sv/ipv4_dotted_quad_checker_top.sv @@
// Dotted-quad IPv4 address checker. Feed the string one UTF-16 code unit
// per word on the req_ channel and mark its final unit with req_tlast; one
// rsp_ word then carries a flag that is 1 when the string is a valid
// dotted-decimal address (7 to 15 units, four fields of ASCII digits split
// by dots, each field nonempty, at most 255, and at most four units
// including its closing dot). Words other than the last give no response.
// The block takes one word every cycle: a word goes from the input register
// through the scan logic into the scan state register, and that state
// update is what sets the rate. The response for a string is written to the
// result register when its last word leaves the input register.
// The state clears itself after each string, so strings may follow back to
// back; only a stalled response with a pending last word holds the input.
module ipv4_dotted_quad_checker_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ipv4dq_pkg::UNIT_W-1:0]   req_tdata,   // [15:0] code_unit
   input  logic                            req_tlast,   // last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ipv4dq_pkg::RSP_W-1:0]    rsp_tdata    // [0] valid_res, [7:1] zero
);
   import ipv4dq_pkg::*;

   `include "ipv4_dotted_quad_checker_top_macros.svh"

   // input register
   logic              s1_vld_ff, s1_vld_in;
   logic [UNIT_W-1:0] s1_unit_ff;
   logic              s1_last_ff;

   // scan state
   scan_state_type    st_ff, st_in;
   scan_state_type    st_step;
   logic              string_ok;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_res_ff, rsp_res_in;

   logic              out_free;
   logic              s1_fire;
   logic              req_fire;

   ipv4dq_unit_step u_step (
      .cur_state  (st_ff),
      .code_unit  (s1_unit_ff),
      .next_state (st_step),
      .string_ok  (string_ok)
   );

   // A non-last word only touches the scan state; a last word needs room
   // in the result register.
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s1_fire    = s1_vld_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_vld_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_fire) begin
         s1_vld_in = 1'b0;
      end
   end

   // Advance the scan; clear it once the last word is scored.
   always_comb begin
      st_in = st_ff;
      if (s1_fire) begin
         st_in = s1_last_ff ? SCAN_CLEAR : st_step;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_res_in = rsp_res_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_vld_in = 1'b1;
         rsp_res_in = string_ok;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         st_ff      <= SCAN_CLEAR;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         st_ff      <= st_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload: hold unless a new word is taken.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_unit_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, rsp_res_ff};

   `IPV4DQ_ASSERT_NEXT(a_last_clears, clock, reset, s1_fire && s1_last_ff,
      st_ff == SCAN_CLEAR, "scan state not cleared after last word")
   `IPV4DQ_ASSERT_NEXT(a_last_gives_rsp, clock, reset, s1_fire && s1_last_ff,
      rsp_vld_ff, "last word did not produce a response")
   `IPV4DQ_ASSERT_NOW(a_field_units, clock, reset, 1'b1,
      st_ff.field_chars <= FIELD_UNITS_MAX, "field unit count beyond limit")
   `IPV4DQ_ASSERT_NOW(a_value_needs_digit, clock, reset, st_ff.field_value != '0,
      st_ff.field_has_digit, "field value without a digit")
   `IPV4DQ_ASSERT_NOW(a_stall_holds_input, clock, reset, s1_vld_ff && !s1_fire,
      !req_tready, "input taken while stage is stalled")

endmodule
